// ----- src/idll_pkg.sv -----
// Shared constants for the indexed doubly linked list block.
package idll_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int OP_W         = 3;
  localparam int POS_W        = 8;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int LEN_W        = 7;

  localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd4;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // where an operation acts
  localparam logic [1:0] AT_TAIL = 2'd0;
  localparam logic [1:0] AT_HEAD = 2'd1;
  localparam logic [1:0] AT_POS  = 2'd2;

endpackage

// ----- src/idll_node_mem.sv -----
// Node store: data word, next link and previous link per slot.
module idll_node_mem #(
  parameter int CAPACITY = idll_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic [$clog2(CAPACITY)-1:0]        rd_addr,
  output logic [idll_pkg::WORD_W-1:0]        rd_data,
  output logic [$clog2(CAPACITY+1)-1:0]      rd_next,
  output logic [$clog2(CAPACITY+1)-1:0]      rd_prev,
  input  logic                               data_we,
  input  logic [$clog2(CAPACITY)-1:0]        data_wa,
  input  logic [idll_pkg::WORD_W-1:0]        data_wd,
  input  logic                               next_we,
  input  logic [$clog2(CAPACITY)-1:0]        next_wa,
  input  logic [$clog2(CAPACITY+1)-1:0]      next_wd,
  input  logic                               prev_we,
  input  logic [$clog2(CAPACITY)-1:0]        prev_wa,
  input  logic [$clog2(CAPACITY+1)-1:0]      prev_wd
);

  localparam int LW = $clog2(CAPACITY+1);

  logic [idll_pkg::WORD_W-1:0] data_mem [CAPACITY];
  logic [LW-1:0]               next_mem [CAPACITY];
  logic [LW-1:0]               prev_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_wa] <= data_wd;
    rd_data <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    rd_next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_prev <= prev_mem[rd_addr];
  end

endmodule

// ----- src/idll_alloc.sv -----
// Slot allocator: fresh-slot counter backed by a stack of released slots.
module idll_alloc #(
  parameter int CAPACITY = idll_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        give,
  input  logic [$clog2(CAPACITY)-1:0] give_slot,
  output logic [$clog2(CAPACITY)-1:0] slot
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);

  logic [SW-1:0] stack_mem [CAPACITY];
  logic [SW-1:0] stack_rd;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] top_m1;
  logic          use_fresh;

  assign top_m1    = top_r - CW'(1);
  assign use_fresh = (fresh_r < CW'(CAPACITY));
  assign slot      = use_fresh ? fresh_r[SW-1:0] : stack_rd;

  always_comb begin
    fresh_nxt = fresh_r;
    top_nxt   = top_r;
    if (take) begin
      if (use_fresh) fresh_nxt = fresh_r + CW'(1);
      else           top_nxt   = top_m1;
    end else if (give) begin
      top_nxt = top_r + CW'(1);
    end
  end

  // stack top is read every cycle; a take never follows a give directly
  always_ff @(posedge clk) begin
    if (give) stack_mem[top_r[SW-1:0]] <= give_slot;
    stack_rd <= stack_mem[top_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= '0;
      top_r   <= '0;
    end else begin
      fresh_r <= fresh_nxt;
      top_r   <= top_nxt;
    end
  end

endmodule

// ----- src/indexed_doubly_linked_list.sv -----
// Top level: indexed doubly linked list with command sequencer.
//
// Input words (in_*) carry one command: opcode, position and value. Each
// accepted command gives exactly one output word (out_*): status, removed
// data word and list length after the command.
// Commands run one at a time. A command is taken only while the sequencer is
// idle; the result then sits in an output register, so the next command can
// be accepted while a result still waits for out_tready.
// States from accept to result valid (the next word can be accepted then):
//   no-op, full pool or empty list   FIN
//   add / delete at head or tail     ALLOC, W1, W2 / RD, RDW, UNL, then FIN
//   delete at position k             WALK, STEP until node k, RDW, UNL, FIN
//   insert at position k             ALLOC, WALK, STEP until node k, RDW, W1, W2, FIN
// The indexed walk follows one next link per cycle through the registered
// read port of the node memory.
// Slots come from a fresh counter, then from a stack of released slots, so no
// clearing pass is needed after reset.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. While the receiver stalls, the result is held and a command that
// has finished waits in its final state until the output register frees.
module indexed_doubly_linked_list #(
  parameter int CAPACITY = idll_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], position[10:3], value[42:11], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], removed_value[33:2], length[40:34], zero
);

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY+1);
  localparam int CW = LW;
  localparam int WW = idll_pkg::WORD_W;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALLOC = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_RDW   = 4'd5;
  localparam logic [3:0] S_UNL   = 4'd6;
  localparam logic [3:0] S_W1    = 4'd7;
  localparam logic [3:0] S_W2    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic          ins_r, ins_nxt;
  logic [1:0]    at_r, at_nxt;
  logic [6:0]    k_r, k_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [WW-1:0] v_r, v_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [LW-1:0] c_r, c_nxt;
  logic [LW-1:0] p_r, p_nxt;
  logic [LW-1:0] n_r, n_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [WW-1:0] removed_r, removed_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;

  logic [SW-1:0] rd_addr;
  logic [WW-1:0] rd_data;
  logic [LW-1:0] rd_next, rd_prev;
  logic          data_we, next_we, prev_we;
  logic [SW-1:0] data_wa, next_wa, prev_wa;
  logic [LW-1:0] next_wd, prev_wd;
  logic          take, give;
  logic [SW-1:0] alloc_slot;

  logic [idll_pkg::OP_W-1:0] in_op;
  logic [6:0]    in_k;
  logic          in_acc;
  logic [31:0]   k_ext, cnt_ext;

  assign in_op   = in_tdata[2:0];
  assign in_k    = in_tdata[10] ? 7'd0 : in_tdata[9:3];
  assign in_acc  = in_tvalid && in_tready;
  assign k_ext   = 32'(in_k);
  assign cnt_ext = 32'(count_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  idll_node_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data), .rd_next(rd_next),
    .rd_prev(rd_prev),
    .data_we(data_we), .data_wa(data_wa), .data_wd(v_r),
    .next_we(next_we), .next_wa(next_wa), .next_wd(next_wd),
    .prev_we(prev_we), .prev_wa(prev_wa), .prev_wd(prev_wd)
  );

  idll_alloc #(.CAPACITY(CAPACITY)) u_alloc (
    .clk(clk), .rst_n(rst_n), .take(take), .give(give),
    .give_slot(c_r[SW-1:0]), .slot(alloc_slot)
  );

  always_comb begin
    state_nxt     = state_r;
    ins_nxt       = ins_r;
    at_nxt        = at_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_addr       = c_r[SW-1:0];
    data_we       = 1'b0;
    next_we       = 1'b0;
    prev_we       = 1'b0;
    data_wa       = s_r;
    next_wa       = s_r;
    prev_wa       = s_r;
    next_wd       = n_r;
    prev_wd       = p_r;
    take          = 1'b0;
    give          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          v_nxt       = in_tdata[42:11];
          k_nxt       = in_k;
          removed_nxt = '0;
          status_nxt  = idll_pkg::ST_DONE;
          unique case (in_op) inside
            idll_pkg::OP_ADD_TAIL, idll_pkg::OP_ADD_HEAD, idll_pkg::OP_INS_AT: begin
              ins_nxt = 1'b1;
              if (in_op == idll_pkg::OP_ADD_TAIL)                 at_nxt = idll_pkg::AT_TAIL;
              else if (in_op == idll_pkg::OP_ADD_HEAD || in_k == 7'd0)
                                                                  at_nxt = idll_pkg::AT_HEAD;
              else if (k_ext >= cnt_ext)                          at_nxt = idll_pkg::AT_TAIL;
              else                                                at_nxt = idll_pkg::AT_POS;
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = idll_pkg::ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                state_nxt  = S_ALLOC;
              end
            end
            idll_pkg::OP_DEL_TAIL, idll_pkg::OP_DEL_HEAD, idll_pkg::OP_DEL_AT: begin
              ins_nxt = 1'b0;
              if (count_r == '0) begin
                status_nxt = idll_pkg::ST_EMPTY;
                state_nxt  = S_FIN;
              end else if (in_op == idll_pkg::OP_DEL_TAIL) begin
                at_nxt    = idll_pkg::AT_TAIL;
                c_nxt     = tail_r;
                state_nxt = S_RD;
              end else if (in_op == idll_pkg::OP_DEL_HEAD || in_k == 7'd0) begin
                at_nxt    = idll_pkg::AT_HEAD;
                c_nxt     = head_r;
                state_nxt = S_RD;
              end else if (k_ext + 32'd1 >= cnt_ext) begin
                // position at or past the last node takes the tail
                at_nxt    = idll_pkg::AT_TAIL;
                c_nxt     = tail_r;
                state_nxt = S_RD;
              end else begin
                at_nxt    = idll_pkg::AT_POS;
                cnt_nxt   = in_k;
                state_nxt = S_WALK;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_ALLOC: begin
        take  = 1'b1;
        s_nxt = alloc_slot;
        unique case (at_r)
          idll_pkg::AT_TAIL: begin
            p_nxt     = tail_r;
            n_nxt     = NIL;
            state_nxt = S_W1;
          end
          idll_pkg::AT_HEAD: begin
            p_nxt     = NIL;
            n_nxt     = head_r;
            state_nxt = S_W1;
          end
          default: begin
            cnt_nxt   = k_r;
            state_nxt = S_WALK;
          end
        endcase
      end
      S_WALK: begin
        rd_addr   = head_r[SW-1:0];
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // follow one link per cycle; read address comes from the read data
        rd_addr = rd_next[SW-1:0];
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          c_nxt     = rd_next;
          state_nxt = S_RDW;
        end
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        p_nxt = rd_prev;
        if (ins_r) begin
          n_nxt     = c_r;
          state_nxt = S_W1;
        end else begin
          n_nxt       = rd_next;
          removed_nxt = rd_data;
          state_nxt   = S_UNL;
        end
      end
      S_UNL: begin
        give    = 1'b1;
        next_wa = p_r[SW-1:0];
        next_wd = n_r;
        prev_wa = n_r[SW-1:0];
        prev_wd = p_r;
        if (p_r != NIL) next_we = 1'b1; else head_nxt = n_r;
        if (n_r != NIL) prev_we = 1'b1; else tail_nxt = p_r;
        count_nxt = count_r - CW'(1);
        state_nxt = S_FIN;
      end
      S_W1: begin
        data_we   = 1'b1;
        next_we   = 1'b1;
        prev_we   = 1'b1;
        state_nxt = S_W2;
      end
      S_W2: begin
        next_wa = p_r[SW-1:0];
        next_wd = LW'(s_r);
        prev_wa = n_r[SW-1:0];
        prev_wd = LW'(s_r);
        if (p_r != NIL) next_we = 1'b1; else head_nxt = LW'(s_r);
        if (n_r != NIL) prev_we = 1'b1; else tail_nxt = LW'(s_r);
        count_nxt = count_r + CW'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, idll_pkg::LEN_W'(count_r), removed_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    at_r       <= at_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    v_r        <= v_nxt;
    s_r        <= s_nxt;
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    status_r   <= status_nxt;
    removed_r  <= removed_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("node count above capacity");

  a_unlink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNL) |-> (count_r != '0)) else $error("unlink on empty list");

  a_link_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W2) |-> (count_r < CW'(CAPACITY))) else $error("link into full pool");

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((head_r == NIL) == (count_r == '0)))
    else $error("head pointer disagrees with count");

endmodule
